[src/psdn_pkg.sv]
// ----------------------------------------------------------------------------
// psdn_pkg
// Shared types and constants for the potentiometer smoother / normalizer.
// ----------------------------------------------------------------------------
package psdn_pkg;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 40;
    localparam int PADDR_W   = 4;

    typedef enum logic [1:0] {
        REG_ALPHA     = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_HOLD      = 2'd2
    } reg_idx_t;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CAL    = 1'b1;

    localparam logic [7:0]  ALPHA_RST     = 8'd51;
    localparam logic [15:0] THRESHOLD_RST = 16'd5;
    localparam logic [19:0] HOLD_RST      = 20'd1000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DECIDE,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [31:0] report_time;
        logic [15:0] last_reported;
        logic [15:0] smoothed;
    } chan_state_t;

    typedef struct packed {
        logic [15:0] high;
        logic [15:0] low;
    } chan_cal_t;

endpackage

[src/pot_smoother_deadband_normalizer.sv]
// ----------------------------------------------------------------------------
// pot_smoother_deadband_normalizer
// Per-channel exponential smoothing, change deadband with hold window, and
// normalization against a per-channel calibration range.
//
// Usage:
//   s_* stream carries requests: tuser selects sample (0) or calibration (1).
//   m_* stream carries reports; tuser flags an empty calibration range.
//   APB port holds alpha, change threshold and hold window.
// Sequence per request (from the input transfer):
//   calibration or out-of-range channel: stays idle, ready again next cycle.
//   sample, no report: memory read, smooth, decide + write back.
//   sample with report: the 16-step restoring divider that forms the Q0.16
//   position follows, then the report waits until the output register is
//   free. Clamped and zero cases skip the divider.
// Channel state sits in two single-port synchronous memories (registered
// read); per-channel valid flops make unwritten entries read as zero.
// Reset returns the configuration registers to defaults and clears all valid flags at once.
// A report waits in the output register while m_tready is low; the input
// side keeps taking requests until another report needs that register.
// ----------------------------------------------------------------------------
module pot_smoother_deadband_normalizer #(
    parameter int NUM_CHANNELS = 9
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: channel[3:0], raw_sample[19:4], now_us[51:20],
    //          cal_low_point[67:52], cal_high_point[83:68]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [psdn_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: req_type
    input  logic                             s_tuser,
    // m_tdata: out_channel[3:0], smoothed_value[19:4], normalized[35:20]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [psdn_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: range_error
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psdn_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import psdn_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration
    logic [7:0]  alpha_reg;
    logic [15:0] thresh_reg;
    logic [19:0] hold_reg;
    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= ALPHA_RST;
            thresh_reg <= THRESHOLD_RST;
            hold_reg   <= HOLD_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ALPHA:     alpha_reg  <= pwdata[7:0];
                REG_THRESHOLD: thresh_reg <= pwdata[15:0];
                REG_HOLD:      hold_reg   <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ALPHA:     prdata = {24'd0, alpha_reg};
            REG_THRESHOLD: prdata = {16'd0, thresh_reg};
            REG_HOLD:      prdata = {12'd0, hold_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // input fields
    logic [3:0]  in_chan;
    logic [15:0] in_raw;
    logic [31:0] in_now;
    logic [15:0] in_lo;
    logic [15:0] in_hi;
    logic        in_range;
    logic        s_xfer;
    logic        cal_wr;
    logic        st_rd;
    logic [IDX_W-1:0] in_idx;

    assign in_chan  = s_tdata[3:0];
    assign in_raw   = s_tdata[19:4];
    assign in_now   = s_tdata[51:20];
    assign in_lo    = s_tdata[67:52];
    assign in_hi    = s_tdata[83:68];
    assign in_idx   = IDX_W'(in_chan);
    assign in_range = 32'(in_chan) < NUM_CHANNELS;
    assign s_xfer   = s_tvalid & s_tready;
    assign cal_wr   = s_xfer & in_range & (s_tuser == REQ_CAL);
    assign st_rd    = s_xfer & in_range & (s_tuser == REQ_SAMPLE);

    // state machine
    state_t state_reg, state_next;

    // item and datapath registers
    logic [3:0]       ch_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]      raw_reg;
    logic [31:0]      now_reg;
    chan_state_t      cur_reg;
    logic [15:0]      lo_reg;
    logic [15:0]      hi_reg;
    logic [15:0]      ns_reg;
    logic [15:0]      quo_reg;
    logic [16:0]      rem_reg;
    logic [15:0]      den_reg;
    logic [3:0]       cnt_reg;
    logic             err_reg;

    // memories
    chan_state_t st_mem  [NUM_CHANNELS];
    chan_cal_t   cal_mem [NUM_CHANNELS];
    chan_state_t st_rdata_reg;
    chan_cal_t   cal_rdata_reg;
    logic [NUM_CHANNELS-1:0] st_vld_reg;
    logic [NUM_CHANNELS-1:0] cal_vld_reg;
    logic        st_rvld_reg;
    logic        cal_rvld_reg;
    logic        st_wr;
    chan_state_t st_wdata;

    always_ff @(posedge aclk) begin
        if (cal_wr) begin
            cal_mem[in_idx] <= '{high: in_hi, low: in_lo};
        end
        if (st_rd) begin
            cal_rdata_reg <= cal_mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_wr) begin
            st_mem[idx_reg] <= st_wdata;
        end
        if (st_rd) begin
            st_rdata_reg <= st_mem[in_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg   <= '0;
            cal_vld_reg  <= '0;
            st_rvld_reg  <= 1'b0;
            cal_rvld_reg <= 1'b0;
        end else begin
            if (cal_wr) begin
                cal_vld_reg[in_idx] <= 1'b1;
            end
            if (st_wr) begin
                st_vld_reg[idx_reg] <= 1'b1;
            end
            if (st_rd) begin
                st_rvld_reg  <= st_vld_reg[in_idx];
                cal_rvld_reg <= cal_vld_reg[in_idx];
            end
        end
    end

    // smoothing: old + floor(alpha * (raw - old) / 256)
    chan_state_t      rd_state;
    chan_cal_t        rd_cal;
    logic signed [16:0] delta;
    logic signed [25:0] prod;
    logic signed [25:0] ns_sum;

    assign rd_state = st_rvld_reg  ? st_rdata_reg  : '0;
    assign rd_cal   = cal_rvld_reg ? cal_rdata_reg : '0;
    assign delta    = signed'({1'b0, raw_reg}) - signed'({1'b0, rd_state.smoothed});
    assign prod     = signed'({1'b0, alpha_reg}) * delta;
    assign ns_sum   = signed'(26'(rd_state.smoothed)) + (prod >>> 8);

    // deadband, hold window and normalizer setup
    logic [15:0] diff;
    logic [31:0] elapsed;
    logic        report;
    logic        zero_res;
    logic        div_need;
    logic [15:0] num;
    logic [15:0] den;

    assign diff    = (ns_reg >= cur_reg.last_reported) ? ns_reg - cur_reg.last_reported
                                                       : cur_reg.last_reported - ns_reg;
    assign elapsed = now_reg - cur_reg.report_time;
    assign report  = (diff > thresh_reg) || (elapsed < 32'(hold_reg));

    always_comb begin
        zero_res = 1'b0;
        num      = 16'd0;
        den      = 16'd0;
        if (lo_reg == hi_reg) begin
            zero_res = 1'b1;
        end else if (hi_reg > lo_reg) begin
            zero_res = ns_reg <= lo_reg;
            num      = ns_reg - lo_reg;
            den      = hi_reg - lo_reg;
        end else begin
            zero_res = ns_reg >= lo_reg;
            num      = lo_reg - ns_reg;
            den      = lo_reg - hi_reg;
        end
    end

    assign div_need = !zero_res && (num < den);

    always_comb begin
        st_wdata.smoothed      = ns_reg;
        st_wdata.last_reported = report ? ns_reg  : cur_reg.last_reported;
        st_wdata.report_time   = report ? now_reg : cur_reg.report_time;
    end

    assign st_wr = (state_reg == ST_DECIDE);

    // divider step
    logic [16:0] rem_sh;
    logic        q_bit;
    logic [16:0] rem_nx;

    assign rem_sh = {rem_reg[15:0], 1'b0};
    assign q_bit  = rem_sh >= {1'b0, den_reg};
    assign rem_nx = q_bit ? rem_sh - {1'b0, den_reg} : rem_sh;

    // output register
    logic        m_tvalid_reg;
    logic [15:0] out_smooth_reg;
    logic [15:0] out_norm_reg;
    logic [3:0]  out_ch_reg;
    logic        out_err_reg;
    logic        out_load;

    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (st_rd) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!report) begin
                    state_next = ST_IDLE;
                end else if (div_need) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV: begin
                if (cnt_reg == 4'd15) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_rd) begin
            ch_reg  <= in_chan;
            idx_reg <= in_idx;
            raw_reg <= in_raw;
            now_reg <= in_now;
        end
        if (state_reg == ST_CALC) begin
            ns_reg  <= ns_sum[15:0];
            cur_reg <= rd_state;
            lo_reg  <= rd_cal.low;
            hi_reg  <= rd_cal.high;
        end
        if (state_reg == ST_DECIDE) begin
            err_reg <= (lo_reg == hi_reg);
            rem_reg <= {1'b0, num};
            den_reg <= den;
            cnt_reg <= 4'd0;
            quo_reg <= zero_res ? 16'd0 : 16'hFFFF;
        end
        if (state_reg == ST_DIV) begin
            rem_reg <= rem_nx;
            quo_reg <= {quo_reg[14:0], q_bit};
            cnt_reg <= cnt_reg + 4'd1;
        end
        if (out_load) begin
            out_ch_reg     <= ch_reg;
            out_smooth_reg <= ns_reg;
            out_norm_reg   <= quo_reg;
            out_err_reg    <= err_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_norm_reg, out_smooth_reg, out_ch_reg};
    assign m_tuser  = out_err_reg;

endmodule

[src/psdn_checker.sv]
// ----------------------------------------------------------------------------
// psdn_checker
// Port-level checks for the potentiometer smoother / normalizer.
// ----------------------------------------------------------------------------
module psdn_checker #(
    parameter int NUM_CHANNELS = 9
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [psdn_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import psdn_pkg::*;

    // no report may appear right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled report changed");

    // calibration transfers leave the input ready
    a_cal_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == REQ_CAL |=> s_tready)
        else $error("not ready after calibration transfer");

    a_chan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata[3:0]) < NUM_CHANNELS)
        else $error("report for nonexistent channel");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[35:20] == 16'd0)
        else $error("range error with nonzero position");

endmodule

bind pot_smoother_deadband_normalizer psdn_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_psdn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
